// File: hw/rtl/cwstat_pkg.sv
// Package for the consensus window statistics block.
// Field widths, record decode constants, register indexes and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package cwstat_pkg;

    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 25;
    localparam int QUAL_W      = 8;
    localparam int DEPTH_W     = 8;
    localparam int MATCH_W     = 12;
    localparam int CENTER_W    = 33;
    localparam int SUM_W       = 32;
    localparam int MATCH_SUM_W = 36;
    localparam int MATCH_ACC_W = 37;
    localparam int CODE_W      = 4;
    localparam int CFG_IDX_W   = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BEGIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 2'd3;

    localparam logic [COUNT_W-1:0] WINDOW_SIZE_RESET = 25'd1000;

    // record decode
    localparam logic [CODE_W-1:0]  REF_UNKNOWN  = 4'hf;
    localparam logic [CODE_W-1:0]  REF_GC_A     = 4'd2;
    localparam logic [CODE_W-1:0]  REF_GC_B     = 4'd4;
    localparam logic [MATCH_W-1:0] UNIQUE_LOW   = 12'd8;
    localparam logic [MATCH_W-1:0] UNIQUE_HIGH  = 12'd32;

    typedef struct packed {
        logic [COUNT_W-1:0] window_size;
        logic [QUAL_W-1:0]  min_quality;
        logic [WORD_W-1:0]  range_begin;
        logic [WORD_W-1:0]  range_end;
    } t_cfg;

    // one classified item, front to back
    typedef struct packed {
        logic                covered;
        logic                snp;
        logic                het;
        logic                gc;
        logic                uniq;
        logic [DEPTH_W-1:0]  depth;
        logic [MATCH_W-1:0]  match;
        logic                close;
        logic                report;
        logic [CENTER_W-1:0] center;
    } t_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic [CENTER_W-1:0]    window_center;
        logic [COUNT_W-1:0]     covered_count;
        logic [COUNT_W-1:0]     snp_count;
        logic [COUNT_W-1:0]     het_count;
        logic [COUNT_W-1:0]     gc_count;
        logic [SUM_W-1:0]       depth_sum;
        logic [MATCH_SUM_W-1:0] match_sum;
        logic [COUNT_W-1:0]     unique_count;
        logic [SUM_W-1:0]       unique_depth_sum;
    } t_result;

endpackage

// File: hw/rtl/cwstat_front.sv
// Front end: decodes each record, tracks position and window fill, decides close and report.
// Depends on cwstat_pkg.
`timescale 1ns / 1ps

module cwstat_front #(
    parameter int MAX_WINDOW    = 16777216,
    parameter int POSITION_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cwstat_pkg::t_cfg              i_cfg,
    input  logic                          i_accept,
    input  logic [cwstat_pkg::WORD_W-1:0] i_low_word,
    input  logic [cwstat_pkg::WORD_W-1:0] i_high_word,
    input  logic                          i_seq_selected,
    input  logic                          i_last_of_sequence,
    output cwstat_pkg::t_cls              o_cls
);

    localparam logic [cwstat_pkg::COUNT_W-1:0] MAX_WS = cwstat_pkg::COUNT_W'(MAX_WINDOW);

    logic [POSITION_BITS-1:0]          r_position;
    logic [POSITION_BITS-1:0]          n_position;
    logic [cwstat_pkg::COUNT_W-1:0]    r_win_count;
    logic [cwstat_pkg::COUNT_W-1:0]    n_win_count;

    logic [cwstat_pkg::CODE_W-1:0]     ref_code;
    logic [cwstat_pkg::CODE_W-1:0]     cns_code;
    logic [cwstat_pkg::QUAL_W-1:0]     qual;
    logic [cwstat_pkg::DEPTH_W-1:0]    depth;
    logic [cwstat_pkg::MATCH_W-1:0]    match;
    logic [2:0]                        cns_ones;
    logic                              covered;
    logic [cwstat_pkg::COUNT_W-1:0]    ws;
    logic [cwstat_pkg::COUNT_W-1:0]    count;
    logic                              close;
    logic [cwstat_pkg::CENTER_W-1:0]   center;
    logic                              in_range;

    always_comb begin
        ref_code = i_high_word[31:28];
        cns_code = i_high_word[27:24];
        qual     = i_high_word[23:16];
        depth    = i_low_word[7:0];
        match    = i_low_word[31:20];
        cns_ones = 3'(cns_code[0]) + 3'(cns_code[1]) + 3'(cns_code[2]) + 3'(cns_code[3]);
        covered  = (ref_code != cwstat_pkg::REF_UNKNOWN) && (qual >= i_cfg.min_quality);

        // zero means one, oversize clamps
        if (i_cfg.window_size == '0) begin
            ws = cwstat_pkg::COUNT_W'(1);
        end else if (i_cfg.window_size > MAX_WS) begin
            ws = MAX_WS;
        end else begin
            ws = i_cfg.window_size;
        end

        count  = r_win_count + cwstat_pkg::COUNT_W'(1);
        close  = (count >= ws) || i_last_of_sequence;
        center = cwstat_pkg::CENTER_W'(r_position)
               + cwstat_pkg::CENTER_W'(ws[cwstat_pkg::COUNT_W-1:1])
               + cwstat_pkg::CENTER_W'(1);
        // range is off when begin is not below end
        in_range = (i_cfg.range_begin >= i_cfg.range_end)
                || ((center >= cwstat_pkg::CENTER_W'(i_cfg.range_begin))
                    && (center <= cwstat_pkg::CENTER_W'(i_cfg.range_end)));

        o_cls.covered = covered;
        o_cls.snp     = covered && (ref_code != cns_code);
        o_cls.het     = covered && (cns_ones == 3'd2);
        o_cls.gc      = covered && ((ref_code == cwstat_pkg::REF_GC_A)
                                 || (ref_code == cwstat_pkg::REF_GC_B));
        o_cls.uniq    = covered && (match >= cwstat_pkg::UNIQUE_LOW)
                                && (match <= cwstat_pkg::UNIQUE_HIGH);
        o_cls.depth   = covered ? depth : '0;
        o_cls.match   = covered ? match : '0;
        o_cls.close   = close;
        o_cls.report  = close && i_seq_selected && in_range;
        o_cls.center  = center;
    end

    always_comb begin
        n_win_count = (close) ? '0 : count;
        n_position  = (i_last_of_sequence) ? '0 : r_position + POSITION_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_win_count <= '0;
        end else if (i_accept) begin
            r_position  <= n_position;
            r_win_count <= n_win_count;
        end
    end

endmodule

// File: hw/rtl/cwstat_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on cwstat_pkg.
`timescale 1ns / 1ps

module cwstat_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  cwstat_pkg::t_cls          i_data,
    input  logic                      i_pop,
    output cwstat_pkg::t_cls          o_data,
    output cwstat_pkg::t_queue_status o_status
);

    cwstat_pkg::t_cls r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;

    always_comb begin
        o_data         = r_mem[r_rd_ptr];
        o_status.full  = (r_count == 2'd2);
        o_status.empty = (r_count == 2'd0);
        n_count        = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

// File: hw/rtl/cwstat_back.sv
// Back end: window accumulators and the output register.
// Depends on cwstat_pkg.
`timescale 1ns / 1ps

module cwstat_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cwstat_pkg::t_cls    i_cls,
    input  logic                i_avail,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output cwstat_pkg::t_result o_result
);

    logic [cwstat_pkg::COUNT_W-1:0]     r_covered, n_covered;
    logic [cwstat_pkg::COUNT_W-1:0]     r_snp, n_snp;
    logic [cwstat_pkg::COUNT_W-1:0]     r_het, n_het;
    logic [cwstat_pkg::COUNT_W-1:0]     r_gc, n_gc;
    logic [cwstat_pkg::COUNT_W-1:0]     r_uniq, n_uniq;
    logic [cwstat_pkg::SUM_W-1:0]       r_depth, n_depth;
    logic [cwstat_pkg::SUM_W-1:0]       r_unique_depth, n_unique_depth;
    logic [cwstat_pkg::MATCH_ACC_W-1:0] r_match, n_match;
    logic                               r_out_valid;
    cwstat_pkg::t_result                r_result;
    logic                               out_free;

    always_comb begin
        n_covered      = r_covered + cwstat_pkg::COUNT_W'(i_cls.covered);
        n_snp          = r_snp + cwstat_pkg::COUNT_W'(i_cls.snp);
        n_het          = r_het + cwstat_pkg::COUNT_W'(i_cls.het);
        n_gc           = r_gc + cwstat_pkg::COUNT_W'(i_cls.gc);
        n_uniq         = r_uniq + cwstat_pkg::COUNT_W'(i_cls.uniq);
        n_depth        = r_depth + cwstat_pkg::SUM_W'(i_cls.depth);
        n_unique_depth = r_unique_depth
                       + (i_cls.uniq ? cwstat_pkg::SUM_W'(i_cls.depth) : '0);
        n_match        = r_match + cwstat_pkg::MATCH_ACC_W'(i_cls.match);

        out_free = !r_out_valid || !i_out_stall;
        // an item that reports waits for room in the output register
        o_pop    = i_avail && (!i_cls.report || out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_covered      <= '0;
            r_snp          <= '0;
            r_het          <= '0;
            r_gc           <= '0;
            r_uniq         <= '0;
            r_depth        <= '0;
            r_unique_depth <= '0;
            r_match        <= '0;
        end else if (o_pop) begin
            if (i_cls.close) begin
                r_covered      <= '0;
                r_snp          <= '0;
                r_het          <= '0;
                r_gc           <= '0;
                r_uniq         <= '0;
                r_depth        <= '0;
                r_unique_depth <= '0;
                r_match        <= '0;
            end else begin
                r_covered      <= n_covered;
                r_snp          <= n_snp;
                r_het          <= n_het;
                r_gc           <= n_gc;
                r_uniq         <= n_uniq;
                r_depth        <= n_depth;
                r_unique_depth <= n_unique_depth;
                r_match        <= n_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cls.report) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.report) begin
            r_result.window_center    <= i_cls.center;
            r_result.covered_count    <= n_covered;
            r_result.snp_count        <= n_snp;
            r_result.het_count        <= n_het;
            r_result.gc_count         <= n_gc;
            r_result.depth_sum        <= n_depth;
            r_result.match_sum        <= n_match[cwstat_pkg::MATCH_SUM_W-1:0];
            r_result.unique_count     <= n_uniq;
            r_result.unique_depth_sum <= n_unique_depth;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// File: hw/rtl/consensus_window_statistics.sv
// Top level of the consensus window statistics block: configuration registers,
// front end, queue and back end. Depends on cwstat_pkg and the cwstat_* modules.
`timescale 1ns / 1ps

// Takes one packed consensus record per cycle while o_in_stall is low, with no gaps
// needed between items. A record is decoded and classified by the front end on the
// cycle it is taken, then sits in a two-entry queue; the back end folds it into the
// window sums when it pops it and loads a result into the output register when a
// reported window closes, so o_out_valid rises once the closing item has left the
// queue. The output register plus the queue let the input keep flowing while one
// result waits; a held result stalls the input only once both queue entries fill.
// Configuration writes apply to items taken after the write edge.
module consensus_window_statistics #(
    parameter int MAX_WINDOW    = 16777216,
    parameter int POSITION_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [cwstat_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cwstat_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [cwstat_pkg::WORD_W-1:0]         i_low_word,
    input  logic [cwstat_pkg::WORD_W-1:0]         i_high_word,
    input  logic                                  i_seq_selected,
    input  logic                                  i_last_of_sequence,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [cwstat_pkg::CENTER_W-1:0]       o_window_center,
    output logic [cwstat_pkg::COUNT_W-1:0]        o_covered_count,
    output logic [cwstat_pkg::COUNT_W-1:0]        o_snp_count,
    output logic [cwstat_pkg::COUNT_W-1:0]        o_het_count,
    output logic [cwstat_pkg::COUNT_W-1:0]        o_gc_count,
    output logic [cwstat_pkg::SUM_W-1:0]          o_depth_sum,
    output logic [cwstat_pkg::MATCH_SUM_W-1:0]    o_match_sum,
    output logic [cwstat_pkg::COUNT_W-1:0]        o_unique_count,
    output logic [cwstat_pkg::SUM_W-1:0]          o_unique_depth_sum
);

    cwstat_pkg::t_cfg          r_cfg;
    cwstat_pkg::t_cls          front_cls;
    cwstat_pkg::t_cls          queue_cls;
    cwstat_pkg::t_queue_status queue_status;
    cwstat_pkg::t_result       result;
    logic                      accept;
    logic                      pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_size <= cwstat_pkg::WINDOW_SIZE_RESET;
            r_cfg.min_quality <= '0;
            r_cfg.range_begin <= '0;
            r_cfg.range_end   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cwstat_pkg::CFG_WINDOW_SIZE: begin
                    r_cfg.window_size <= i_cfg_data[cwstat_pkg::COUNT_W-1:0];
                end
                cwstat_pkg::CFG_MIN_QUALITY: begin
                    r_cfg.min_quality <= i_cfg_data[cwstat_pkg::QUAL_W-1:0];
                end
                cwstat_pkg::CFG_RANGE_BEGIN: begin
                    r_cfg.range_begin <= i_cfg_data;
                end
                cwstat_pkg::CFG_RANGE_END: begin
                    r_cfg.range_end <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = queue_status.full;
    assign accept     = i_in_valid && !queue_status.full;

    cwstat_front #(
        .MAX_WINDOW    (MAX_WINDOW),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_accept           (accept),
        .i_low_word         (i_low_word),
        .i_high_word        (i_high_word),
        .i_seq_selected     (i_seq_selected),
        .i_last_of_sequence (i_last_of_sequence),
        .o_cls              (front_cls)
    );

    cwstat_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_data   (front_cls),
        .i_pop    (pop),
        .o_data   (queue_cls),
        .o_status (queue_status)
    );

    cwstat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (queue_cls),
        .i_avail     (!queue_status.empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_window_center    = result.window_center;
    assign o_covered_count    = result.covered_count;
    assign o_snp_count        = result.snp_count;
    assign o_het_count        = result.het_count;
    assign o_gc_count         = result.gc_count;
    assign o_depth_sum        = result.depth_sum;
    assign o_match_sum        = result.match_sum;
    assign o_unique_count     = result.unique_count;
    assign o_unique_depth_sum = result.unique_depth_sum;

    // every sub-count is a subset of the covered positions
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_snp_count <= o_covered_count)
                     && (o_het_count <= o_covered_count)
                     && (o_gc_count <= o_covered_count)
                     && (o_unique_count <= o_covered_count)
                     && (o_unique_depth_sum <= o_depth_sum))
        else $error("window counts exceed covered count");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // a queue pop never happens on an empty queue, so a stall needs two held items
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(accept))
        else $error("input stall rose without a new item");

endmodule

// File: tb/testbench.sv
// Testbench for consensus_window_statistics: records and register settings in, window sums out,
// each result checked against a window-sum predictor held in a small scoreboard class.
// Depends on cwstat_pkg and the consensus_window_statistics RTL.
`timescale 1ns / 1ps

class window_scoreboard;
    cwstat_pkg::t_result window_sums_due[$];
    int unsigned errors;

    logic [cwstat_pkg::COUNT_W-1:0] window_cap;
    logic [cwstat_pkg::COUNT_W-1:0] window_size;
    logic [cwstat_pkg::QUAL_W-1:0]  min_quality;
    logic [cwstat_pkg::WORD_W-1:0]  range_begin;
    logic [cwstat_pkg::WORD_W-1:0]  range_end;

    logic [cwstat_pkg::WORD_W-1:0]      position;
    logic [cwstat_pkg::COUNT_W-1:0]     in_window;
    logic [cwstat_pkg::COUNT_W-1:0]     n_covered, n_snp, n_het, n_gc, unique_hits;
    logic [cwstat_pkg::SUM_W-1:0]       depth_total, unique_depth_total;
    logic [cwstat_pkg::MATCH_ACC_W-1:0] match_total;

    function new(logic [cwstat_pkg::COUNT_W-1:0] cap);
        window_cap = cap;
        window_size = cwstat_pkg::WINDOW_SIZE_RESET;
        min_quality = '0;
        range_begin = '0;
        range_end = '0;
        position = '0;
        in_window = '0;
        errors = 0;
        clear_sums();
    endfunction

    function void clear_sums();
        n_covered = '0;
        n_snp = '0;
        n_het = '0;
        n_gc = '0;
        unique_hits = '0;
        depth_total = '0;
        unique_depth_total = '0;
        match_total = '0;
    endfunction

    function void set_register(logic [cwstat_pkg::CFG_IDX_W-1:0] idx,
                               logic [cwstat_pkg::WORD_W-1:0] data);
        case (idx)
            cwstat_pkg::CFG_WINDOW_SIZE: window_size = data[cwstat_pkg::COUNT_W-1:0];
            cwstat_pkg::CFG_MIN_QUALITY: min_quality = data[cwstat_pkg::QUAL_W-1:0];
            cwstat_pkg::CFG_RANGE_BEGIN: range_begin = data;
            cwstat_pkg::CFG_RANGE_END:   range_end = data;
            default: ;
        endcase
    endfunction

    // fold one accepted record into the running window and queue the sums of a reported window it closes
    function void fold_record(input logic [cwstat_pkg::WORD_W-1:0] lo,
                              input logic [cwstat_pkg::WORD_W-1:0] hi,
                              input logic sel, input logic last);
        logic [cwstat_pkg::CODE_W-1:0]   rcode;
        logic [cwstat_pkg::CODE_W-1:0]   ccode;
        logic [cwstat_pkg::QUAL_W-1:0]   qual;
        logic [cwstat_pkg::DEPTH_W-1:0]  depth;
        logic [cwstat_pkg::MATCH_W-1:0]  score;
        logic [cwstat_pkg::COUNT_W-1:0]  ws;
        logic [cwstat_pkg::COUNT_W-1:0]  count;
        logic [cwstat_pkg::CENTER_W-1:0] center;
        cwstat_pkg::t_result             sums;
        rcode = hi[31:28];
        ccode = hi[27:24];
        qual = hi[23:16];
        depth = lo[7:0];
        score = lo[31:20];
        ws = window_size;
        if (ws == '0) ws = cwstat_pkg::COUNT_W'(1);
        if (ws > window_cap) ws = window_cap;

        if (rcode != cwstat_pkg::REF_UNKNOWN && qual >= min_quality) begin
            n_covered = n_covered + cwstat_pkg::COUNT_W'(1);
            if (score >= cwstat_pkg::UNIQUE_LOW && score <= cwstat_pkg::UNIQUE_HIGH) begin
                unique_hits = unique_hits + cwstat_pkg::COUNT_W'(1);
                unique_depth_total = unique_depth_total + cwstat_pkg::SUM_W'(depth);
            end
            if ($countones(ccode) == 2) n_het = n_het + cwstat_pkg::COUNT_W'(1);
            if (ccode != rcode) n_snp = n_snp + cwstat_pkg::COUNT_W'(1);
            if (rcode == cwstat_pkg::REF_GC_A || rcode == cwstat_pkg::REF_GC_B)
                n_gc = n_gc + cwstat_pkg::COUNT_W'(1);
            depth_total = depth_total + cwstat_pkg::SUM_W'(depth);
            match_total = match_total + cwstat_pkg::MATCH_ACC_W'(score);
        end

        count = in_window + cwstat_pkg::COUNT_W'(1);
        if (count >= ws || last) begin
            center = cwstat_pkg::CENTER_W'(position)
                   + cwstat_pkg::CENTER_W'(ws[cwstat_pkg::COUNT_W-1:1])
                   + cwstat_pkg::CENTER_W'(1);
            if (sel && (range_begin >= range_end ||
                        (center >= {1'b0, range_begin} && center <= {1'b0, range_end}))) begin
                sums.window_center = center;
                sums.covered_count = n_covered;
                sums.snp_count = n_snp;
                sums.het_count = n_het;
                sums.gc_count = n_gc;
                sums.depth_sum = depth_total;
                sums.match_sum = match_total[cwstat_pkg::MATCH_SUM_W-1:0];
                sums.unique_count = unique_hits;
                sums.unique_depth_sum = unique_depth_total;
                window_sums_due.push_back(sums);
            end
            clear_sums();
            count = '0;
        end
        in_window = count;

        if (last) begin
            position = '0;
            in_window = '0;
        end else begin
            position = position + cwstat_pkg::WORD_W'(1);
        end
    endfunction

    task report(string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_window(cwstat_pkg::t_result got);
        cwstat_pkg::t_result want;
        if (window_sums_due.size() == 0) begin
            report($sformatf("window result at center %0h with none pending",
                             got.window_center));
            return;
        end
        want = window_sums_due.pop_front();
        compare_field("window_center", got.window_center, want.window_center);
        compare_field("covered_count", got.covered_count, want.covered_count);
        compare_field("snp_count", got.snp_count, want.snp_count);
        compare_field("het_count", got.het_count, want.het_count);
        compare_field("gc_count", got.gc_count, want.gc_count);
        compare_field("depth_sum", got.depth_sum, want.depth_sum);
        compare_field("match_sum", got.match_sum, want.match_sum);
        compare_field("unique_count", got.unique_count, want.unique_count);
        compare_field("unique_depth_sum", got.unique_depth_sum, want.unique_depth_sum);
    endtask
endclass

module testbench;
    localparam logic [cwstat_pkg::COUNT_W-1:0] MAX_WINDOW = 25'h100_0000;
    localparam int RANDOM_RECORDS = 1450;
    localparam int SETTLE_CYCLES = 8;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [cwstat_pkg::CFG_IDX_W-1:0]   i_cfg_index = cwstat_pkg::CFG_WINDOW_SIZE;
    logic [cwstat_pkg::WORD_W-1:0]      i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic [cwstat_pkg::WORD_W-1:0]      i_low_word = '0;
    logic [cwstat_pkg::WORD_W-1:0]      i_high_word = '0;
    logic                               i_seq_selected = 1'b0;
    logic                               i_last_of_sequence = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [cwstat_pkg::CENTER_W-1:0]    o_window_center;
    logic [cwstat_pkg::COUNT_W-1:0]     o_covered_count;
    logic [cwstat_pkg::COUNT_W-1:0]     o_snp_count;
    logic [cwstat_pkg::COUNT_W-1:0]     o_het_count;
    logic [cwstat_pkg::COUNT_W-1:0]     o_gc_count;
    logic [cwstat_pkg::SUM_W-1:0]       o_depth_sum;
    logic [cwstat_pkg::MATCH_SUM_W-1:0] o_match_sum;
    logic [cwstat_pkg::COUNT_W-1:0]     o_unique_count;
    logic [cwstat_pkg::SUM_W-1:0]       o_unique_depth_sum;

    window_scoreboard board;
    int records_taken = 0;
    int sender_idle = 30;
    int receiver_stall = 55;
    int seq_left = 0;
    logic seq_sel = 1'b1;

    consensus_window_statistics i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_low_word         (i_low_word),
        .i_high_word        (i_high_word),
        .i_seq_selected     (i_seq_selected),
        .i_last_of_sequence (i_last_of_sequence),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_window_center    (o_window_center),
        .o_covered_count    (o_covered_count),
        .o_snp_count        (o_snp_count),
        .o_het_count        (o_het_count),
        .o_gc_count         (o_gc_count),
        .o_depth_sum        (o_depth_sum),
        .o_match_sum        (o_match_sum),
        .o_unique_count     (o_unique_count),
        .o_unique_depth_sum (o_unique_depth_sum)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_window({o_window_center, o_covered_count, o_snp_count, o_het_count,
                                o_gc_count, o_depth_sum, o_match_sum, o_unique_count,
                                o_unique_depth_sum});
    end

    task automatic send_record(input logic [cwstat_pkg::WORD_W-1:0] lo,
                               input logic [cwstat_pkg::WORD_W-1:0] hi,
                               input logic sel, input logic last);
        while ($urandom_range(99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_low_word <= lo;
        i_high_word <= hi;
        i_seq_selected <= sel;
        i_last_of_sequence <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.fold_record(lo, hi, sel, last);
        records_taken++;
        // receiver-heavy stalling, then sender-heavy idling, then none
        if (records_taken < 500) begin
            sender_idle = 30;
            receiver_stall = 55;
        end else if (records_taken < 1000) begin
            sender_idle = 55;
            receiver_stall = 30;
        end else begin
            sender_idle = 0;
            receiver_stall = 0;
        end
    endtask

    task automatic send_fields(input logic [cwstat_pkg::CODE_W-1:0] rcode,
                               input logic [cwstat_pkg::CODE_W-1:0] ccode,
                               input logic [cwstat_pkg::QUAL_W-1:0] qual,
                               input logic [cwstat_pkg::DEPTH_W-1:0] depth,
                               input logic [cwstat_pkg::MATCH_W-1:0] score, input logic sel,
                               input logic last);
        logic [15:0] pad_hi;
        logic [11:0] pad_lo;
        pad_hi = 16'($urandom);
        pad_lo = 12'($urandom);
        send_record({score, pad_lo, depth}, {rcode, ccode, qual, pad_hi}, sel, last);
    endtask

    // stop sending and wait out every pending window plus the pipeline
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.window_sums_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_register(input logic [cwstat_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [cwstat_pkg::WORD_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_register(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sequence_item();
        logic [cwstat_pkg::CODE_W-1:0]  rcode;
        logic [cwstat_pkg::CODE_W-1:0]  ccode;
        logic [cwstat_pkg::QUAL_W-1:0]  qual;
        logic [cwstat_pkg::DEPTH_W-1:0] depth;
        logic [cwstat_pkg::MATCH_W-1:0] score;
        if (seq_left == 0) begin
            seq_left = $urandom_range(1, 40);
            seq_sel = ($urandom_range(9) != 0);
        end
        if ($urandom_range(9) == 0) begin
            send_record($urandom, $urandom, seq_sel, seq_left == 1);
        end else begin
            rcode = ($urandom_range(7) == 0) ? cwstat_pkg::REF_UNKNOWN
                                             : cwstat_pkg::CODE_W'($urandom_range(14));
            ccode = $urandom_range(1) ? rcode : cwstat_pkg::CODE_W'($urandom_range(15));
            qual = cwstat_pkg::QUAL_W'($urandom);
            depth = cwstat_pkg::DEPTH_W'($urandom);
            score = $urandom_range(1) ? cwstat_pkg::MATCH_W'($urandom_range(40))
                                      : cwstat_pkg::MATCH_W'($urandom);
            send_fields(rcode, ccode, qual, depth, score, seq_sel, seq_left == 1);
        end
        seq_left--;
    endtask

    task automatic random_settings();
        logic [cwstat_pkg::COUNT_W-1:0] ws;
        logic [cwstat_pkg::QUAL_W-1:0]  qual;
        logic [6:0]                     ws_pad;
        logic [23:0]                    qual_pad;
        logic [cwstat_pkg::WORD_W-1:0]  rb;
        logic [cwstat_pkg::WORD_W-1:0]  re;
        ws_pad = 7'($urandom);
        qual_pad = 24'($urandom);
        case ($urandom_range(9))
            0: ws = '0;
            1: ws = $urandom_range(1) ? MAX_WINDOW : ({1'b1, 24'd0} | 25'($urandom));
            default: ws = cwstat_pkg::COUNT_W'($urandom_range(1, 24));
        endcase
        case ($urandom_range(3))
            0: qual = '0;
            1: qual = '1;
            default: qual = cwstat_pkg::QUAL_W'($urandom);
        endcase
        case ($urandom_range(2))
            0: begin
                rb = $urandom_range(200);
                re = $urandom_range(rb);
            end
            1: begin
                rb = $urandom_range(60);
                re = rb + $urandom_range(1, 80);
            end
            default: begin
                rb = '0;
                re = '1;
            end
        endcase
        program_register(cwstat_pkg::CFG_WINDOW_SIZE, {ws_pad, ws});
        program_register(cwstat_pkg::CFG_MIN_QUALITY, {qual_pad, qual});
        program_register(cwstat_pkg::CFG_RANGE_BEGIN, rb);
        program_register(cwstat_pkg::CFG_RANGE_END, re);
    endtask

    initial begin
        int random_start;
        int phase_len;
        board = new(MAX_WINDOW);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unknown reference, all-zero record, closing het/gc record
        send_record('1, '1, 1'b1, 1'b0);
        send_record('0, '0, 1'b1, 1'b0);
        send_fields(cwstat_pkg::REF_GC_A, 4'h3, 8'd0, 8'hff, cwstat_pkg::UNIQUE_LOW,
                    1'b1, 1'b1);
        settle();

        // zero window size acts as one; highest quality floor; unique bounds
        program_register(cwstat_pkg::CFG_WINDOW_SIZE, 32'hFE00_0000);
        program_register(cwstat_pkg::CFG_MIN_QUALITY, 32'hFFFF_FFFF);
        program_register(cwstat_pkg::CFG_RANGE_BEGIN, 32'd0);
        program_register(cwstat_pkg::CFG_RANGE_END, 32'd0);
        send_fields(4'd1, 4'd1, 8'hff, 8'h80, cwstat_pkg::UNIQUE_HIGH, 1'b1, 1'b0);
        send_fields(cwstat_pkg::REF_GC_B, 4'h6, 8'hfe, 8'h01, 12'd33, 1'b1, 1'b0);
        send_fields(cwstat_pkg::REF_GC_B, 4'h5, 8'hff, 8'hff, 12'd7, 1'b1, 1'b0);
        send_fields(4'd0, 4'hf, 8'hff, 8'h00, 12'hfff, 1'b0, 1'b0);
        send_fields(4'd14, 4'd9, 8'hff, 8'hff, 12'd20, 1'b1, 1'b1);
        settle();

        // reporting range: windows centered inside and past it
        program_register(cwstat_pkg::CFG_WINDOW_SIZE, 32'd2);
        program_register(cwstat_pkg::CFG_MIN_QUALITY, 32'd0);
        program_register(cwstat_pkg::CFG_RANGE_BEGIN, 32'd3);
        program_register(cwstat_pkg::CFG_RANGE_END, 32'd5);
        for (int i = 0; i < 6; i++)
            send_fields(cwstat_pkg::CODE_W'($urandom_range(14)), cwstat_pkg::CODE_W'($urandom),
                        cwstat_pkg::QUAL_W'($urandom), cwstat_pkg::DEPTH_W'($urandom),
                        cwstat_pkg::MATCH_W'($urandom_range(40)), 1'b1, i == 5);
        settle();

        // oversized window clamps; only the end of sequence closes it
        program_register(cwstat_pkg::CFG_WINDOW_SIZE, 32'hFFFF_FFFF);
        program_register(cwstat_pkg::CFG_RANGE_BEGIN, 32'd0);
        program_register(cwstat_pkg::CFG_RANGE_END, 32'hFFFF_FFFF);
        for (int i = 0; i < 3; i++)
            send_fields(cwstat_pkg::REF_GC_A, cwstat_pkg::CODE_W'($urandom),
                        cwstat_pkg::QUAL_W'($urandom), cwstat_pkg::DEPTH_W'($urandom),
                        cwstat_pkg::MATCH_W'($urandom_range(40)), 1'b1, i == 2);
        settle();

        // shrink the window while one is open
        program_register(cwstat_pkg::CFG_WINDOW_SIZE, 32'd5);
        program_register(cwstat_pkg::CFG_RANGE_BEGIN, 32'hFFFF_FFFF);
        for (int i = 0; i < 3; i++)
            send_fields(cwstat_pkg::CODE_W'($urandom_range(14)), cwstat_pkg::CODE_W'($urandom),
                        cwstat_pkg::QUAL_W'($urandom), cwstat_pkg::DEPTH_W'($urandom),
                        cwstat_pkg::MATCH_W'($urandom), 1'b1, 1'b0);
        settle();
        program_register(cwstat_pkg::CFG_WINDOW_SIZE, 32'd2);
        send_fields(cwstat_pkg::REF_GC_B, 4'h4, 8'h10, 8'h22, 12'd9, 1'b1, 1'b0);
        send_fields(4'd3, 4'h3, 8'h10, 8'h33, 12'd10, 1'b1, 1'b1);

        random_start = records_taken;
        while (records_taken - random_start < RANDOM_RECORDS) begin
            settle();
            random_settings();
            phase_len = $urandom_range(60, 140);
            for (int i = 0; i < phase_len; i++)
                send_sequence_item();
            // sender holds off until all windows are out
            if ($urandom_range(1)) settle();
        end

        settle();
        if (board.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/cwstat_pkg.sv
hw/rtl/cwstat_front.sv
hw/rtl/cwstat_queue.sv
hw/rtl/cwstat_back.sv
hw/rtl/consensus_window_statistics.sv
tb/testbench.sv
